/* design/rcl_pkg.sv */
// Types, codes and the linearization table of the RTD calibrate/linearize block.
// No dependencies; rcl_div and the core refer to it by scoped names.
`default_nettype none

package rcl_pkg;

    localparam int TABLE_POINTS = 17;
    localparam int TAB_IDX_W    = $clog2(TABLE_POINTS);
    localparam int TAB_CNT_W    = $clog2(TABLE_POINTS + 1);

    // divider geometry: 48-bit dividend, 19-bit divisor, 6-bit step count
    localparam int DIV_W  = 48;
    localparam int DSR_W  = 19;
    localparam int STEP_W = 6;

    localparam logic [15:0] SCALE_SPAN = 16'd23915;

    localparam logic [1:0] CAP_NONE = 2'd0;
    localparam logic [1:0] CAP_ZERO = 2'd1;
    localparam logic [1:0] CAP_FULL = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HIGH  = 2'd1;
    localparam logic [1:0] ST_LOW   = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    localparam logic signed [11:0] TAB_TEMP [TABLE_POINTS] = '{
        -12'sd100, -12'sd50, 12'sd0, 12'sd50, 12'sd100, 12'sd150, 12'sd200,
        12'sd250, 12'sd300, 12'sd350, 12'sd400, 12'sd450, 12'sd500, 12'sd670,
        12'sd840, 12'sd1000, 12'sd1180
    };

    localparam logic signed [15:0] TAB_CODE [TABLE_POINTS] = '{
        -16'sd2440, -16'sd1250, 16'sd0, 16'sd1230, 16'sd2500, 16'sd3724,
        16'sd4955, 16'sd6210, 16'sd7418, 16'sd8651, 16'sd9833, 16'sd11052,
        16'sd12238, 16'sd16280, 16'sd20246, 16'sd23915, 16'sd28121
    };

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_DIV1, S_DIV1W, S_CAL, S_SPAN, S_MUL2, S_DIV2,
        S_DIV2W, S_SRCH, S_MUL3, S_MUL4, S_DIV3, S_DIV3W, S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* design/rcl_if.sv */
// Valid/ready channels of the RTD calibrate/linearize block.
// No dependencies.
`default_nettype none

interface rcl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [15:0] sample_first;
    logic [15:0] sample_second;
    logic [1:0]  capture;

    modport source (output valid, channel, sample_first, sample_second, capture,
                    input ready);
    modport sink   (input valid, channel, sample_first, sample_second, capture,
                    output ready);
endinterface

interface rcl_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] temperature;
    logic [1:0]         status;

    modport source (output valid, temperature, status, input ready);
    modport sink   (input valid, temperature, status, output ready);
endinterface

`default_nettype wire

/* design/rcl_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on rcl_pkg for the request and response structs.
`default_nettype none

module rcl_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rcl_pkg::t_div_req i_req,
    output rcl_pkg::t_div_rsp      o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [rcl_pkg::STEP_W-1:0]   r_cnt;
    logic [rcl_pkg::DIV_W-1:0]    r_dvd;
    logic [rcl_pkg::DSR_W:0]      r_rem;
    logic [rcl_pkg::DSR_W-1:0]    r_dsr;

    logic [rcl_pkg::DSR_W:0]      w_trial;
    logic                         w_fit;

    assign w_trial = {r_rem[rcl_pkg::DSR_W-1:0], r_dvd[rcl_pkg::DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rcl_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_trial - {1'b0, r_dsr} : w_trial;
            r_dvd <= {r_dvd[rcl_pkg::DIV_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule

`default_nettype wire

/* design/rtd_calibrate_linearize_core.sv */
// RTD calibration and table linearization: sequencer, shared multiplier, state.
// Depends on rcl_pkg, rcl_if and rcl_div.
`default_nettype none

// Channel   Dir  Word
// i_in      in   channel, sample_first, sample_second, capture
// o_out     out  temperature, status
//
// Each word runs through up to three passes of the shared divider (32, 46 and 26
// quotient bits), a scan of the table and up to four multiply steps. Input ready
// is high only while the sequencer is idle. A finished result waits in the output
// register; the next word is accepted meanwhile and holds in its last step only
// if the previous result is still not taken.
// Reset sets every zero word to 0 and every full word to 65535.

module rtd_calibrate_linearize_core #(
    parameter int CHANNELS = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcl_in_if.sink     i_in,
    rcl_out_if.source  o_out
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TP   = rcl_pkg::TABLE_POINTS;
    localparam int IW   = rcl_pkg::TAB_IDX_W;
    localparam int KW   = rcl_pkg::TAB_CNT_W;

    rcl_pkg::t_state r_state, n_state;

    logic [15:0] r_zero_cal [CHANNELS];
    logic [15:0] r_full_cal [CHANNELS];

    logic [CH_W-1:0]     r_ch;
    logic [1:0]          r_cap;
    logic [15:0]         r_s1, r_s2;
    logic [15:0]         r_zero, r_full;
    logic                r_fault;
    logic                r_neg;
    logic signed [32:0]  r_corr;
    logic signed [33:0]  r_c;
    logic [31:0]         r_mag;
    logic signed [51:0]  r_prod;
    logic signed [15:0]  r_p;
    logic [KW-1:0]       r_k;
    logic signed [25:0]  r_num;

    logic               r_out_valid;
    logic signed [11:0] r_temp;
    logic [1:0]         r_status;

    logic               w_accept;
    logic               w_in_range;
    logic               w_out_free;
    logic signed [33:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [51:0] w_prod;
    logic signed [33:0] w_c;
    logic signed [34:0] w_diff;
    logic [15:0]        w_span;
    logic               w_above;
    logic [IW-1:0]      w_hi, w_lo;
    logic signed [15:0] w_c0, w_c1;
    logic signed [11:0] w_t0, w_t1;
    logic [12:0]        w_den;
    logic [25:0]        w_num_mag;
    logic [25:0]        w_num_rnd;
    logic [31:0]        w_x_mag;
    logic [15:0]        w_q16;

    rcl_pkg::t_div_req w_div_req;
    rcl_pkg::t_div_rsp w_div_rsp;

    rcl_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_range = {2'b0, i_in.channel} < 4'(CHANNELS);
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_hi  = r_k[IW-1:0];
    assign w_lo  = IW'(r_k - 1'b1);
    assign w_c0  = rcl_pkg::TAB_CODE[w_lo];
    assign w_c1  = rcl_pkg::TAB_CODE[w_hi];
    assign w_t0  = rcl_pkg::TAB_TEMP[w_lo];
    assign w_t1  = rcl_pkg::TAB_TEMP[w_hi];
    assign w_den = 13'(w_c1 - w_c0);

    assign w_above = (r_k < KW'(TP)) && (r_p >= rcl_pkg::TAB_CODE[w_hi]);

    assign w_c = 34'($signed({1'b0, r_s2, 1'b0})) - 34'($signed({1'b0, r_s1}))
               + 34'(r_corr);
    assign w_diff = 35'(r_c) - 35'($signed({1'b0, r_zero}));
    assign w_span = r_full - r_zero;

    assign w_x_mag   = r_prod[51] ? 32'(-r_prod) : r_prod[31:0];
    assign w_num_mag = r_num[25] ? 26'(-r_num) : 26'(r_num);
    assign w_num_rnd = {w_num_mag[24:0], 1'b0} + 26'(w_den);
    assign w_q16     = w_div_rsp.quotient[15:0];

    assign w_prod = 52'(w_mul_a) * 52'(w_mul_b);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcl_pkg::S_IDLE: begin
                if (w_accept) n_state = w_in_range ? rcl_pkg::S_MUL1 : rcl_pkg::S_OUT;
            end
            rcl_pkg::S_MUL1:  n_state = rcl_pkg::S_DIV1;
            rcl_pkg::S_DIV1:  n_state = (r_zero == 16'd0) ? rcl_pkg::S_CAL
                                                           : rcl_pkg::S_DIV1W;
            rcl_pkg::S_DIV1W: if (w_div_rsp.done) n_state = rcl_pkg::S_CAL;
            rcl_pkg::S_CAL:   n_state = rcl_pkg::S_SPAN;
            rcl_pkg::S_SPAN:  n_state = (r_fault || w_span == 16'd0) ? rcl_pkg::S_OUT
                                                                     : rcl_pkg::S_MUL2;
            rcl_pkg::S_MUL2:  n_state = rcl_pkg::S_DIV2;
            rcl_pkg::S_DIV2:  n_state = rcl_pkg::S_DIV2W;
            rcl_pkg::S_DIV2W: if (w_div_rsp.done) n_state = rcl_pkg::S_SRCH;
            rcl_pkg::S_SRCH: begin
                if (!w_above) begin
                    if (r_k == KW'(TP) || r_k == '0) n_state = rcl_pkg::S_OUT;
                    else                             n_state = rcl_pkg::S_MUL3;
                end
            end
            rcl_pkg::S_MUL3:  n_state = rcl_pkg::S_MUL4;
            rcl_pkg::S_MUL4:  n_state = rcl_pkg::S_DIV3;
            rcl_pkg::S_DIV3:  n_state = rcl_pkg::S_DIV3W;
            rcl_pkg::S_DIV3W: if (w_div_rsp.done) n_state = rcl_pkg::S_OUT;
            rcl_pkg::S_OUT:   if (w_out_free) n_state = rcl_pkg::S_IDLE;
            default:          n_state = rcl_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: handshake, multiplier operands, divider requests
    always_comb begin
        i_in.ready = 1'b0;
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_div_req  = '0;
        unique case (r_state)
            rcl_pkg::S_IDLE: i_in.ready = 1'b1;
            rcl_pkg::S_MUL1: begin
                w_mul_a = 34'($signed({1'b0, r_s1}) - $signed({1'b0, r_s2}));
                w_mul_b = 18'($signed({1'b0, r_s1}));
            end
            rcl_pkg::S_DIV1: begin
                // (x / zero) / 6 truncated equals x / (6 * zero) truncated
                w_div_req.start    = r_zero != 16'd0;
                w_div_req.dividend = {w_x_mag, 16'd0};
                w_div_req.divisor  = 19'({r_zero, 2'b0}) + 19'({r_zero, 1'b0});
                w_div_req.steps    = rcl_pkg::STEP_W'(32);
            end
            rcl_pkg::S_MUL2: begin
                w_mul_a = 34'($signed({1'b0, r_mag}));
                w_mul_b = 18'($signed({1'b0, rcl_pkg::SCALE_SPAN}));
            end
            rcl_pkg::S_DIV2: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {r_prod[45:0], 2'b0};
                w_div_req.divisor  = 19'(w_span);
                w_div_req.steps    = rcl_pkg::STEP_W'(46);
            end
            rcl_pkg::S_MUL3: begin
                w_mul_a = 34'(17'(r_p) - 17'(w_c0));
                w_mul_b = 18'(w_t1) - 18'(w_t0);
            end
            rcl_pkg::S_MUL4: begin
                w_mul_a = 34'(w_t0);
                w_mul_b = 18'($signed({1'b0, w_den}));
            end
            rcl_pkg::S_DIV3: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {w_num_rnd, 22'd0};
                w_div_req.divisor  = 19'({w_den, 1'b0});
                w_div_req.steps    = rcl_pkg::STEP_W'(26);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_zero_cal[i] <= 16'd0;
                r_full_cal[i] <= 16'hFFFF;
            end
        end else if (r_state == rcl_pkg::S_CAL) begin
            if (r_cap == rcl_pkg::CAP_ZERO) r_zero_cal[r_ch] <= w_c[15:0];
            if (r_cap == rcl_pkg::CAP_FULL) r_full_cal[r_ch] <= w_c[15:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rcl_pkg::S_IDLE: begin
                r_ch    <= CH_W'(i_in.channel);
                r_cap   <= i_in.capture;
                r_s1    <= i_in.sample_first;
                r_s2    <= i_in.sample_second;
                r_zero  <= r_zero_cal[CH_W'(i_in.channel)];
                r_full  <= r_full_cal[CH_W'(i_in.channel)];
                r_temp  <= '0;
                r_status <= rcl_pkg::ST_FAULT;
            end
            rcl_pkg::S_MUL1: r_prod <= w_prod;
            rcl_pkg::S_DIV1: begin
                r_fault <= r_zero == 16'd0;
                r_neg   <= r_prod[51];
                r_corr  <= '0;
            end
            rcl_pkg::S_DIV1W: begin
                r_corr <= r_neg ? -33'($signed({1'b0, w_div_rsp.quotient[31:0]}))
                                :  33'($signed({1'b0, w_div_rsp.quotient[31:0]}));
            end
            rcl_pkg::S_CAL: begin
                r_c <= w_c;
                if (r_cap == rcl_pkg::CAP_ZERO) r_zero <= w_c[15:0];
                if (r_cap == rcl_pkg::CAP_FULL) r_full <= w_c[15:0];
            end
            rcl_pkg::S_SPAN: begin
                r_neg <= w_diff[34];
                r_mag <= w_diff[34] ? 32'(-w_diff) : w_diff[31:0];
            end
            rcl_pkg::S_MUL2: r_prod <= w_prod;
            rcl_pkg::S_DIV2W: begin
                r_p <= r_neg ? $signed(-w_q16) : $signed(w_q16);
                r_k <= '0;
            end
            rcl_pkg::S_SRCH: begin
                if (w_above) begin
                    r_k <= r_k + 1'b1;
                end else if (r_k == KW'(TP)) begin
                    r_temp   <= rcl_pkg::TAB_TEMP[TP-1];
                    r_status <= rcl_pkg::ST_HIGH;
                end else if (r_k == '0) begin
                    r_temp   <= rcl_pkg::TAB_TEMP[0];
                    r_status <= rcl_pkg::ST_LOW;
                end
            end
            rcl_pkg::S_MUL3: r_prod <= w_prod;
            rcl_pkg::S_MUL4: r_num  <= 26'(r_prod) + 26'(w_prod);
            rcl_pkg::S_DIV3: r_neg  <= r_num[25];
            rcl_pkg::S_DIV3W: begin
                r_temp   <= r_neg ? -$signed(w_div_rsp.quotient[11:0])
                                  :  $signed(w_div_rsp.quotient[11:0]);
                r_status <= rcl_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    // output register: load when free, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rcl_pkg::S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rcl_pkg::S_OUT && w_out_free) begin
            o_out.temperature <= r_temp;
            o_out.status      <= r_status;
        end
    end

    assign o_out.valid = r_out_valid;

endmodule

`default_nettype wire

/* bench/tb_rtd_calibrate_linearize_core.sv */
// Testbench of the RTD calibrate/linearize core: directed and random words
// checked against an in-bench predictor. Depends on rcl_pkg, rcl_if and the core.
`timescale 1ns / 1ps

module tb_rtd_calibrate_linearize_core;

    localparam int NCH = 3;

    typedef struct {
        logic signed [11:0] temperature;
        logic [1:0]         status;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rcl_in_if  in_ch();
    rcl_out_if out_ch();

    rtd_calibrate_linearize_core #(.CHANNELS(NCH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [15:0] zero_word [NCH];
    logic [15:0] full_word [NCH];
    t_reading    pending_readings [$];
    int          errors = 0;
    int          words_sent = 0;
    int          readings_seen = 0;
    bit          long_hold = 1'b0;

    // table lookup with interpolation rounded half away from zero
    function automatic t_reading linearize(longint p);
        t_reading r;
        longint c0, c1, t0, t1, den, num, mag, q;
        int k;
        k = 0;
        while (k < rcl_pkg::TABLE_POINTS && !(p < longint'(rcl_pkg::TAB_CODE[k]))) k++;
        if (k >= rcl_pkg::TABLE_POINTS) begin
            r.status = rcl_pkg::ST_HIGH;
            r.temperature = rcl_pkg::TAB_TEMP[rcl_pkg::TABLE_POINTS-1];
        end else if (k == 0) begin
            r.status = rcl_pkg::ST_LOW;
            r.temperature = rcl_pkg::TAB_TEMP[0];
        end else begin
            c0 = rcl_pkg::TAB_CODE[k-1]; c1 = rcl_pkg::TAB_CODE[k];
            t0 = rcl_pkg::TAB_TEMP[k-1]; t1 = rcl_pkg::TAB_TEMP[k];
            den = c1 - c0;
            num = (p - c0) * (t1 - t0) + t0 * den;
            mag = num < 0 ? -num : num;
            q = (2 * mag + den) / (2 * den);
            r.status = rcl_pkg::ST_OK;
            r.temperature = 12'(num < 0 ? -q : q);
        end
        return r;
    endfunction

    function automatic t_reading calibrate_word(logic [1:0] ch, logic [15:0] s1w,
                                                logic [15:0] s2w, logic [1:0] cap);
        t_reading r;
        longint s1, s2, corr, c, span, scaled;
        logic [15:0] w;
        bit fault;
        r.temperature = '0;
        r.status = rcl_pkg::ST_FAULT;
        if (ch >= NCH) return r;
        s1 = s1w; s2 = s2w; corr = 0; fault = 1'b0;
        if (zero_word[ch] != 0) corr = ((s1 - s2) * s1 / longint'(zero_word[ch])) / 6;
        else fault = 1'b1;
        c = 2 * s2 - s1 + corr;
        if (cap == rcl_pkg::CAP_ZERO) zero_word[ch] = c[15:0];
        else if (cap == rcl_pkg::CAP_FULL) full_word[ch] = c[15:0];
        span = longint'(16'(full_word[ch] - zero_word[ch]));
        if (span == 0) fault = 1'b1;
        if (fault) return r;
        scaled = (c - longint'(zero_word[ch])) * 23915 / span;
        w = scaled[15:0];
        return linearize(longint'($signed(w)));
    endfunction

    task automatic send_word(logic [1:0] ch, logic [15:0] s1, logic [15:0] s2,
                             logic [1:0] cap);
        int idle;
        idle = $urandom_range(0, 6);
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.channel <= ch;
        in_ch.sample_first <= s1;
        in_ch.sample_second <= s2;
        in_ch.capture <= cap;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_readings.push_back(calibrate_word(ch, s1, s2, cap));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // receiver: random stalls per word, with one long hold on request
    initial begin
        int hold;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                long_hold = 1'b0;
            end else begin
                hold = $urandom_range(0, 6);
                if (hold > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (hold) @(negedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
                while (!out_ch.valid) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            readings_seen++;
            if (pending_readings.size() == 0) begin
                $error("reading with nothing expected: temperature %0d status %0d",
                       out_ch.temperature, out_ch.status);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                if (out_ch.temperature !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d",
                           want.temperature, out_ch.temperature);
                    errors++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed;
        // zero word is zero: fault
        send_word(2'd0, 16'd1000, 16'd1000, rcl_pkg::CAP_NONE);
        // capture with zero word zero
        send_word(2'd0, 16'd100, 16'd100, rcl_pkg::CAP_ZERO);
        send_word(2'd0, 16'd30000, 16'd30000, rcl_pkg::CAP_FULL);
        send_word(2'd0, 16'd0, 16'd0, rcl_pkg::CAP_NONE);
        send_word(2'd0, 16'd65535, 16'd65535, rcl_pkg::CAP_NONE);
        send_word(2'd0, 16'd65535, 16'd0, rcl_pkg::CAP_NONE);
        send_word(2'd0, 16'd0, 16'd65535, rcl_pkg::CAP_NONE);
        send_word(2'd0, 16'd5000, 16'd5200, 2'd3);   // capture code 3
        send_word(2'd3, 16'd500, 16'd600, rcl_pkg::CAP_ZERO);    // channel out of range
        send_word(2'd1, 16'd700, 16'd700, rcl_pkg::CAP_ZERO);
        send_word(2'd1, 16'd700, 16'd700, rcl_pkg::CAP_FULL);    // span zero
        send_word(2'd1, 16'd9000, 16'd9000, rcl_pkg::CAP_FULL);
        send_word(2'd1, 16'd8000, 16'd8200, rcl_pkg::CAP_NONE);
        send_word(2'd2, 16'd200, 16'd200, rcl_pkg::CAP_ZERO);
        send_word(2'd2, 16'd3000, 16'd3000, rcl_pkg::CAP_FULL);
        send_word(2'd2, 16'd190, 16'd190, rcl_pkg::CAP_NONE);    // just below the zero word
        send_word(2'd2, 16'd6000, 16'd6000, rcl_pkg::CAP_NONE);  // scaled code wraps negative: below table
        send_word(2'd2, 16'd1600, 16'd1600, rcl_pkg::CAP_NONE);
        drain();
    endtask

    task automatic random_word(bit wide);
        logic [1:0] ch, cap;
        logic [15:0] s1, s2;
        ch = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        s1 = 16'($urandom);
        s2 = wide ? 16'($urandom) : 16'(s1 + $urandom_range(0, 400) - 200);
        cap = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : rcl_pkg::CAP_NONE;
        send_word(ch, s1, s2, cap);
    endtask

    task automatic test_calibrated_random;
        int ch, n, z;
        for (n = 0; n < 800; n++) begin
            if (n % 100 == 0) begin
                // recalibrate channels with a plausible zero and full word
                for (ch = 0; ch < NCH; ch++) begin
                    z = $urandom_range(100, 20000);
                    send_word(2'(ch), 16'(z), 16'(z), rcl_pkg::CAP_ZERO);
                    z = z + $urandom_range(1, 30000);
                    send_word(2'(ch), 16'(z), 16'(z), rcl_pkg::CAP_FULL);
                end
            end
            random_word($urandom_range(0, 3) == 0);
        end
        drain();
    endtask

    task automatic test_backpressure;
        int n;
        long_hold = 1'b1;
        for (n = 0; n < 20; n++) random_word(1'b0);
        drain();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.channel = '0;
        in_ch.sample_first = '0;
        in_ch.sample_second = '0;
        in_ch.capture = '0;
        for (int i = 0; i < NCH; i++) begin
            zero_word[i] = 16'd0;
            full_word[i] = 16'hFFFF;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_calibrated_random();
        $display("Covered %0d words and %0d readings: faults, captures, table ends,",
                 words_sent, readings_seen);
        $display("interpolation, out-of-range channels and a long output stall.");
        if (errors == 0 && pending_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/rcl_pkg.sv
design/rcl_if.sv
design/rcl_div.sv
design/rtd_calibrate_linearize_core.sv
bench/tb_rtd_calibrate_linearize_core.sv
